@@ hw/rtl/mrd_pkg.sv @@
// Shared constants and controller/datapath interface types for the masked
// RMS difference core. No dependencies.
`timescale 1ns / 1ps

package mrd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 24;

  localparam int SUM_BITS   = 56;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_STEPS  = SUM_BITS + FRAC_BITS;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int ROOT_STEPS = ROOT_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int SDIFF_W = 17;
  localparam int ADIFF_W = 16;
  localparam int RMS_W   = 24;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_step;
    logic emit;
  } mrd_cmd_t;

  typedef struct packed {
    logic last_ready;
    logic pipe_last;
  } mrd_stat_t;

endpackage

@@ hw/rtl/mrd_datapath.sv @@
// Datapath of the masked RMS difference core: voxel pipeline, saturating
// accumulators, bit-serial divider and square root. Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_datapath #(
  parameter int SAMPLE_BITS = mrd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = mrd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic [SAMPLE_BITS-1:0]        in_ref_sample,
  input  logic [SAMPLE_BITS-1:0]        in_test_sample,
  input  logic                          in_mask_bit,
  input  logic                          in_last_voxel,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  mrd_pkg::mrd_cmd_t             cmd,
  output mrd_pkg::mrd_stat_t            stat,
  output logic                          out_strobe,
  output logic [mrd_pkg::SDIFF_W-1:0]   out_signed_diff,
  output logic [mrd_pkg::ADIFF_W-1:0]   out_abs_diff,
  output logic                          out_rms_valid,
  output logic [mrd_pkg::RMS_W-1:0]     out_rms_value,
  output logic                          out_saturated
);

  localparam int SB  = SAMPLE_BITS;
  localparam int SW  = mrd_pkg::SUM_BITS;
  localparam int QW  = mrd_pkg::DIV_STEPS;
  localparam int RW  = mrd_pkg::ROOT_BITS;
  localparam int RMW = RW + 2;
  localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [63:0] LIM_FULL = ((64'd1 << SAMPLE_BITS) - 64'd1) << 8;
  localparam logic [mrd_pkg::RMS_W-1:0] RMS_LIM =
      (LIM_FULL > 64'hFFFFFF) ? 24'hFFFFFF : LIM_FULL[mrd_pkg::RMS_W-1:0];

  logic use_mask_r;

  logic          v1_r, cnt1_r, last1_r;
  logic [SB:0]   sd1_r;
  logic [SB-1:0] mag1_r;

  logic            v2_r, cnt2_r, last2_r;
  logic [SB:0]     sd2_r;
  logic [SB-1:0]   mag2_r;
  logic [2*SB-1:0] sq2_r;

  logic [SW-1:0]         sum_r;
  logic [COUNT_BITS-1:0] total_r;
  logic                  ovf_r;

  logic [SB:0]   hold_sd_r;
  logic [SB-1:0] hold_ad_r;
  logic          hold_sat_r, zero_r;

  logic [COUNT_BITS-1:0] rem_r, dvs_r;
  logic [QW-1:0]         qr_r;
  logic [RMW-1:0]        srem_r;
  logic [RW-1:0]         root_r;

  logic                      strobe_r, rv_r, sat_r;
  logic [mrd_pkg::SDIFF_W-1:0] sd_out_r;
  logic [mrd_pkg::ADIFF_W-1:0] ad_out_r;
  logic [mrd_pkg::RMS_W-1:0]   rms_r;

  logic          counted;
  logic [SB:0]   diff;
  logic [SB:0]   diff_neg;

  logic [SW:0]           sum_add;
  logic [SW-1:0]         sum_nxt;
  logic [COUNT_BITS-1:0] total_nxt;
  logic                  ovf_nxt;
  logic                  acc_en;

  logic [COUNT_BITS:0]   div_sh;
  logic [COUNT_BITS:0]   div_sub;
  logic                  div_bit;

  logic [RMW+1:0] sq_sh;
  logic [RMW+1:0] sq_trial;
  logic [RMW+1:0] sq_sub;
  logic           sq_bit;

  logic [31:0] sd_wide, ad_wide;
  logic [31:0] sd2_wide, ad2_wide;
  logic [mrd_pkg::RMS_W-1:0] rms_final;
  logic [RW-1:0] lim_wide;

  assign counted  = !use_mask_r || in_mask_bit;
  assign diff     = {in_ref_sample[SB-1], in_ref_sample} -
                    {in_test_sample[SB-1], in_test_sample};
  assign diff_neg = ~diff + {{SB{1'b0}}, 1'b1};

  assign acc_en  = v2_r && cnt2_r;
  assign sum_add = {1'b0, sum_r} + {{(SW + 1 - 2*SB){1'b0}}, sq2_r};

  always_comb begin
    sum_nxt   = sum_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    if (acc_en) begin
      if (sum_add[SW]) begin
        sum_nxt = SUM_MAX;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_add[SW-1:0];
      end
      if (total_r == CNT_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        total_nxt = total_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  assign div_sh  = {rem_r, qr_r[QW-1]};
  assign div_sub = div_sh - {1'b0, dvs_r};
  assign div_bit = !div_sub[COUNT_BITS] || (div_sh >= {1'b0, dvs_r});

  assign sq_sh    = {srem_r, qr_r[SW-1:SW-2]};
  assign sq_trial = {{2{1'b0}}, root_r, 2'b01};
  assign sq_bit   = sq_sh >= sq_trial;
  assign sq_sub   = sq_sh - sq_trial;

  assign sd_wide  = {{(32 - SB - 1){hold_sd_r[SB]}}, hold_sd_r};
  assign ad_wide  = {{(32 - SB){1'b0}}, hold_ad_r};
  assign sd2_wide = {{(32 - SB - 1){sd2_r[SB]}}, sd2_r};
  assign ad2_wide = {{(32 - SB){1'b0}}, mag2_r};
  assign lim_wide = {{(RW - mrd_pkg::RMS_W){1'b0}}, RMS_LIM};

  always_comb begin
    if (zero_r) begin
      rms_final = '0;
    end else if (qr_r[QW-1:SW] != '0 || root_r > lim_wide) begin
      rms_final = RMS_LIM;
    end else begin
      rms_final = root_r[mrd_pkg::RMS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mask_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      sum_r      <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        use_mask_r <= cfg_wdata;
      end
      v1_r <= in_take;
      v2_r <= v1_r;
      if (v2_r && last2_r) begin
        sum_r   <= '0;
        total_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        total_r <= total_nxt;
        ovf_r   <= ovf_nxt;
      end
      strobe_r <= (v2_r && !last2_r) || cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    cnt1_r  <= counted;
    last1_r <= in_last_voxel;
    sd1_r   <= counted ? diff : '0;
    if (!counted) begin
      mag1_r <= '0;
    end else if (diff[SB]) begin
      mag1_r <= diff_neg[SB-1:0];
    end else begin
      mag1_r <= diff[SB-1:0];
    end

    cnt2_r  <= cnt1_r;
    last2_r <= last1_r;
    sd2_r   <= sd1_r;
    mag2_r  <= mag1_r;
    sq2_r   <= mag1_r * mag1_r;

    if (v2_r) begin
      hold_sd_r  <= sd2_r;
      hold_ad_r  <= mag2_r;
      hold_sat_r <= ovf_nxt;
    end

    if (cmd.load) begin
      zero_r <= (total_nxt == '0);
      dvs_r  <= total_nxt;
      rem_r  <= '0;
      qr_r   <= {sum_nxt, {mrd_pkg::FRAC_BITS{1'b0}}};
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.div_step) begin
      if (div_bit) begin
        rem_r <= div_sub[COUNT_BITS-1:0];
      end else begin
        rem_r <= div_sh[COUNT_BITS-1:0];
      end
      qr_r <= {qr_r[QW-2:0], div_bit};
    end else if (cmd.sqrt_step) begin
      if (sq_bit) begin
        srem_r <= sq_sub[RMW-1:0];
      end else begin
        srem_r <= sq_sh[RMW-1:0];
      end
      root_r         <= {root_r[RW-2:0], sq_bit};
      qr_r[SW-1:0]   <= {qr_r[SW-3:0], 2'b00};
    end

    if (v2_r && !last2_r) begin
      sd_out_r <= sd2_wide[mrd_pkg::SDIFF_W-1:0];
      ad_out_r <= ad2_wide[mrd_pkg::ADIFF_W-1:0];
      rv_r     <= 1'b0;
      rms_r    <= '0;
      sat_r    <= ovf_nxt;
    end else if (cmd.emit) begin
      sd_out_r <= sd_wide[mrd_pkg::SDIFF_W-1:0];
      ad_out_r <= ad_wide[mrd_pkg::ADIFF_W-1:0];
      rv_r     <= 1'b1;
      rms_r    <= rms_final;
      sat_r    <= hold_sat_r;
    end
  end

  assign stat.last_ready = v2_r && last2_r;
  assign stat.pipe_last  = (v1_r && last1_r) || (v2_r && last2_r);

  assign out_strobe      = strobe_r;
  assign out_signed_diff = sd_out_r;
  assign out_abs_diff    = ad_out_r;
  assign out_rms_valid   = rv_r;
  assign out_rms_value   = rms_r;
  assign out_saturated   = sat_r;

endmodule

@@ hw/rtl/mrd_ctrl.sv @@
// Controller of the masked RMS difference core: sequences the divide and
// square root on the last item of a volume. Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  mrd_pkg::mrd_stat_t stat,
  output mrd_pkg::mrd_cmd_t  cmd,
  output logic               busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [mrd_pkg::STEP_W-1:0] DIV_LAST  =
      mrd_pkg::STEP_W'(mrd_pkg::DIV_STEPS - 1);
  localparam logic [mrd_pkg::STEP_W-1:0] ROOT_LAST =
      mrd_pkg::STEP_W'(mrd_pkg::ROOT_STEPS - 1);

  logic [1:0]                 state_r, state_nxt;
  logic [mrd_pkg::STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (stat.last_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
          step_nxt  = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = stat.pipe_last || (state_r != ST_IDLE);

endmodule

@@ hw/rtl/masked_rms_difference_core.sv @@
// Top level of the masked RMS difference core: joins controller and datapath.
// Depends on mrd_pkg, mrd_ctrl and mrd_datapath.
`timescale 1ns / 1ps

// Each item gives one result on the out_ ports for a single cycle with
// out_strobe high; the receiver cannot stall, so it must take every result
// as it appears. Items that do not end a volume are taken at one per cycle
// while busy is low. An item with last_voxel set raises busy until its result
// appears: a one-bit-per-cycle divider runs 72 steps and a two-bits-per-cycle
// square root runs 28 steps, both on shared registers. use_mask is written
// through cfg_we and cfg_wdata while idle: the core leaves that to the user.

module masked_rms_difference_core #(
  parameter int SAMPLE_BITS = mrd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = mrd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [SAMPLE_BITS-1:0]      in_ref_sample,
  input  logic [SAMPLE_BITS-1:0]      in_test_sample,
  input  logic                        in_mask_bit,
  input  logic                        in_last_voxel,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  output logic                        out_strobe,
  output logic [mrd_pkg::SDIFF_W-1:0] out_signed_diff,
  output logic [mrd_pkg::ADIFF_W-1:0] out_abs_diff,
  output logic                        out_rms_valid,
  output logic [mrd_pkg::RMS_W-1:0]   out_rms_value,
  output logic                        out_saturated
);

  mrd_pkg::mrd_cmd_t  cmd;
  mrd_pkg::mrd_stat_t stat;
  logic               take;

  assign take = start && !busy;

  mrd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mrd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (take),
    .in_ref_sample   (in_ref_sample),
    .in_test_sample  (in_test_sample),
    .in_mask_bit     (in_mask_bit),
    .in_last_voxel   (in_last_voxel),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_signed_diff (out_signed_diff),
    .out_abs_diff    (out_abs_diff),
    .out_rms_valid   (out_rms_valid),
    .out_rms_value   (out_rms_value),
    .out_saturated   (out_saturated)
  );

endmodule
